@@ hdl/odp_pkg.sv @@
// ----------------------------------------------------------------------------
// odp_pkg
// Shared constants, register codes and helper functions for the ordered
// dither pixel pipeline.
// ----------------------------------------------------------------------------
package odp_pkg;

   // threshold matrix geometry
   localparam int MaxMatrixDim = 8;
   localparam int DimBits      = (MaxMatrixDim > 1) ? $clog2(MaxMatrixDim) : 1;
   localparam int ModBits      = DimBits + 1;
   localparam int TableDepth   = MaxMatrixDim * MaxMatrixDim;
   localparam int AddrBits     = (TableDepth > 1) ? $clog2(TableDepth) : 1;

   // coordinate reduction is split over two pipeline steps
   localparam int CoordBits    = 12;
   localparam int HalfBits     = CoordBits / 2;

   localparam int NumChan      = 3;
   localparam int ProdBits     = 23;
   localparam int SumBits      = 32;

   // 255 * 2^16 plus the rounding half 2^16
   localparam logic signed [SumBits-1:0] SumBias = 32'sd16777216;

   // configuration register indexes
   localparam logic [2:0] CsrBrightness = 3'd0;
   localparam logic [2:0] CsrContrast   = 3'd1;
   localparam logic [2:0] CsrThreshold  = 3'd2;
   localparam logic [2:0] CsrColourMode = 3'd3;
   localparam logic [2:0] CsrInvert     = 3'd4;
   localparam logic [2:0] CsrBits       = 3'd5;
   localparam logic [2:0] CsrSize       = 3'd6;

   typedef logic [7:0]        chan_type;
   typedef logic signed [8:0] entry_type;

   // restoring remainder over HalfBits coordinate bits, divisor at most MaxMatrixDim
   function automatic logic [DimBits-1:0] mod_steps(input logic [DimBits-1:0]  r0,
                                                    input logic [HalfBits-1:0] bits,
                                                    input logic [ModBits-1:0]  sz);
      logic [ModBits-1:0] r;
      r = ModBits'(r0);
      for (int i = HalfBits - 1; i >= 0; i--) begin
         r = {r[ModBits-2:0], bits[i]};
         if (r >= sz) begin
            r = r - sz;
         end
      end
      return r[DimBits-1:0];
   endfunction

   // quantization bits limited to 1..8
   function automatic logic [3:0] clamp_bits(input logic [3:0] b);
      logic [3:0] r;
      if (b == 4'd0) begin
         r = 4'd1;
      end else if (b > 4'd8) begin
         r = 4'd8;
      end else begin
         r = b;
      end
      return r;
   endfunction

   // floor(255 / (2^b - 1))
   function automatic chan_type step_lut(input logic [3:0] b);
      chan_type r;
      case (b)
         4'd1: r = 8'd255;
         4'd2: r = 8'd85;
         4'd3: r = 8'd36;
         4'd4: r = 8'd17;
         4'd5: r = 8'd8;
         4'd6: r = 8'd4;
         4'd7: r = 8'd2;
         4'd8: r = 8'd1;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/ordered_dither_pixel.sv @@
// ----------------------------------------------------------------------------
// ordered_dither_pixel
// Ordered dithering of one pixel per clock, unless stalled, against a loadable threshold
// matrix held in an on-chip synchronous memory.
// ----------------------------------------------------------------------------
//
//   port group | direction | handshake        | carries
//   -----------+-----------+------------------+-------------------------------
//   req_       | in        | valid / stall    | load or pixel request
//   rsp_       | out       | valid / stall    | dithered rgb and alpha
//   csr_       | in        | write enable     | configuration registers
//
// one request per clock unless stalled; each pixel result is registered at every stage
// the matrix memory takes at most one write and one read per unstalled cycle, in request
// order, from the stage 1 registers, so a load is seen by every later pixel
// rsp_stall with a waiting result freezes the whole pipeline and raises req_stall
// reset empties the pipeline and sets the registers to their defaults; matrix contents stay unknown
// loads and pixels with a zero matrix size give no result
//
module ordered_dither_pixel (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [11:0]         req_x_pos,
   input  logic [11:0]         req_y_pos,
   input  logic [7:0]          req_red_in,
   input  logic [7:0]          req_green_in,
   input  logic [7:0]          req_blue_in,
   input  logic [7:0]          req_alpha_in,
   input  logic signed [8:0]   req_matrix_value,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_red_out,
   output logic [7:0]          rsp_green_out,
   output logic [7:0]          rsp_blue_out,
   output logic [7:0]          rsp_alpha_out,

   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [11:0]         csr_wdata
);

   // configuration registers
   logic signed [8:0]  brightness_ff;
   logic [11:0]        contrast_ff;
   logic [11:0]        threshold_ff;
   logic               colour_ff;
   logic               invert_ff;
   logic [3:0]         bits_ff;
   logic [3:0]         size_ff;

   logic               en;

   // stage 1: accepted request, partial remainders
   logic               s1_pix_ff, s1_pix_in;
   logic               s1_wr_ff, s1_wr_in;
   logic [odp_pkg::AddrBits-1:0] s1_addr_ff, s1_addr_in;
   odp_pkg::entry_type s1_val_ff;
   logic [odp_pkg::DimBits-1:0]  s1_xr_ff, s1_xr_in, s1_yr_ff, s1_yr_in;
   logic [odp_pkg::HalfBits-1:0] s1_xlo_ff, s1_ylo_ff;
   odp_pkg::chan_type  s1_c_ff [odp_pkg::NumChan];
   odp_pkg::chan_type  s1_c_in [odp_pkg::NumChan];
   odp_pkg::chan_type  s1_a_ff;

   // stage 2: matrix entry read back
   logic               s2_pix_ff;
   odp_pkg::chan_type  s2_c_ff [odp_pkg::NumChan];
   odp_pkg::chan_type  s2_a_ff;
   odp_pkg::entry_type mem_rd_ff;
   logic [odp_pkg::AddrBits-1:0] rd_idx;

   // stage 3: products
   logic               s3_pix_ff;
   logic signed [odp_pkg::ProdBits-1:0] s3_prodc_ff [odp_pkg::NumChan];
   logic signed [odp_pkg::ProdBits-1:0] s3_prodc_in [odp_pkg::NumChan];
   logic signed [odp_pkg::ProdBits-1:0] s3_prodt_ff, s3_prodt_in;
   odp_pkg::chan_type  s3_a_ff;

   // stage 4: clamped level
   logic               s4_pix_ff;
   odp_pkg::chan_type  s4_q_ff [odp_pkg::NumChan];
   odp_pkg::chan_type  s4_q_in [odp_pkg::NumChan];
   odp_pkg::chan_type  s4_a_ff;

   // stage 5: quantizer index
   logic               s5_pix_ff;
   odp_pkg::chan_type  s5_k_ff [odp_pkg::NumChan];
   odp_pkg::chan_type  s5_k_in [odp_pkg::NumChan];
   odp_pkg::chan_type  s5_a_ff;

   // output register
   logic               rsp_valid_ff;
   odp_pkg::chan_type  rsp_c_ff [odp_pkg::NumChan];
   odp_pkg::chan_type  rsp_c_in [odp_pkg::NumChan];
   odp_pkg::chan_type  rsp_a_ff;

   odp_pkg::entry_type dither_mem [odp_pkg::TableDepth];

   logic [odp_pkg::ModBits-1:0] sz;
   logic [3:0]                  bits_eff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_c_ff[0];
   assign rsp_green_out = rsp_c_ff[1];
   assign rsp_blue_out  = rsp_c_ff[2];
   assign rsp_alpha_out = rsp_a_ff;

   always_comb begin
      if (32'(size_ff) > odp_pkg::MaxMatrixDim) begin
         sz = odp_pkg::ModBits'(odp_pkg::MaxMatrixDim);
      end else begin
         sz = odp_pkg::ModBits'(size_ff);
      end
      bits_eff = odp_pkg::clamp_bits(bits_ff);
   end

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= '0;
         contrast_ff   <= 12'd256;
         threshold_ff  <= 12'd256;
         colour_ff     <= 1'b0;
         invert_ff     <= 1'b0;
         bits_ff       <= 4'd1;
         size_ff       <= 4'd0;
      end else if (csr_write) begin
         case (csr_index)
            odp_pkg::CsrBrightness: brightness_ff <= $signed(csr_wdata[8:0]);
            odp_pkg::CsrContrast:   contrast_ff   <= csr_wdata;
            odp_pkg::CsrThreshold:  threshold_ff  <= csr_wdata;
            odp_pkg::CsrColourMode: colour_ff     <= csr_wdata[0];
            odp_pkg::CsrInvert:     invert_ff     <= csr_wdata[0];
            odp_pkg::CsrBits:       bits_ff       <= csr_wdata[3:0];
            odp_pkg::CsrSize:       size_ff       <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      logic [12:0]       gray_sum;
      odp_pkg::chan_type gray;
      odp_pkg::chan_type src [odp_pkg::NumChan];
      logic              in_range;

      s1_pix_in = req_valid && req_func && (size_ff != 4'd0);
      in_range  = (req_x_pos < 12'(odp_pkg::MaxMatrixDim)) &&
                  (req_y_pos < 12'(odp_pkg::MaxMatrixDim));
      s1_wr_in  = req_valid && !req_func && in_range;
      s1_addr_in = odp_pkg::AddrBits'(
                      odp_pkg::AddrBits'(req_y_pos[odp_pkg::DimBits-1:0]) *
                      odp_pkg::AddrBits'(odp_pkg::MaxMatrixDim) +
                      odp_pkg::AddrBits'(req_x_pos[odp_pkg::DimBits-1:0]));

      // high half of the coordinate reduction
      s1_xr_in = odp_pkg::mod_steps('0, req_x_pos[odp_pkg::CoordBits-1:odp_pkg::HalfBits], sz);
      s1_yr_in = odp_pkg::mod_steps('0, req_y_pos[odp_pkg::CoordBits-1:odp_pkg::HalfBits], sz);

      gray_sum = ({5'd0, req_red_in} * 13'd11) + {1'b0, req_green_in, 4'd0}
               + ({5'd0, req_blue_in} * 13'd5);
      gray     = gray_sum[12:5];
      src[0]   = req_red_in;
      src[1]   = req_green_in;
      src[2]   = req_blue_in;
      for (int i = 0; i < odp_pkg::NumChan; i++) begin
         s1_c_in[i] = colour_ff ? src[i] : gray;
         if (invert_ff) begin
            s1_c_in[i] = ~s1_c_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      logic [odp_pkg::DimBits-1:0] rx, ry;
      rx = odp_pkg::mod_steps(s1_xr_ff, s1_xlo_ff, sz);
      ry = odp_pkg::mod_steps(s1_yr_ff, s1_ylo_ff, sz);
      rd_idx = odp_pkg::AddrBits'(odp_pkg::AddrBits'(ry) *
                                  odp_pkg::AddrBits'(odp_pkg::MaxMatrixDim) +
                                  odp_pkg::AddrBits'(rx));
   end

   // at most one write and one read per unstalled cycle, in request order
   always_ff @(posedge clock) begin
      if (en) begin
         if (s1_wr_ff) begin
            dither_mem[s1_addr_ff] <= s1_val_ff;
         end
         mem_rd_ff <= dither_mem[rd_idx];
      end
   end

   // ---------------------------------------------------------------- stage 3
   always_comb begin
      logic signed [9:0] d;
      for (int i = 0; i < odp_pkg::NumChan; i++) begin
         // 2c - 255, scaled by contrast
         d = $signed({1'b0, s2_c_ff[i], 1'b0}) - 10'sd255;
         s3_prodc_in[i] = d * $signed({1'b0, contrast_ff});
      end
      s3_prodt_in = mem_rd_ff * $signed({1'b0, threshold_ff});
   end

   // ---------------------------------------------------------------- stage 4
   always_comb begin
      logic signed [odp_pkg::SumBits-1:0] common;
      logic signed [odp_pkg::SumBits-1:0] s;
      common = odp_pkg::SumBias + (odp_pkg::SumBits'(brightness_ff) <<< 17)
             + (odp_pkg::SumBits'(s3_prodt_ff) * 32'sd510);
      for (int i = 0; i < odp_pkg::NumChan; i++) begin
         s = (odp_pkg::SumBits'(s3_prodc_ff[i]) <<< 8) + common;
         if (s[odp_pkg::SumBits-1]) begin
            s4_q_in[i] = 8'd0;
         end else if (s[odp_pkg::SumBits-2:25] != '0) begin
            s4_q_in[i] = 8'd255;
         end else begin
            s4_q_in[i] = s[24:17];
         end
      end
   end

   // ---------------------------------------------------------------- stage 5
   always_comb begin
      logic [15:0] a;
      logic [15:0] t;
      logic [15:0] u;
      for (int i = 0; i < odp_pkg::NumChan; i++) begin
         // k = floor((q*(L-1) + 127) / 255), division by 255 as shift-add
         a = (16'(s4_q_ff[i]) << bits_eff) - 16'(s4_q_ff[i]);
         t = a + 16'd127;
         u = t + 16'd1 + (t >> 8);
         s5_k_in[i] = u[15:8];
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      logic [15:0] p;
      for (int i = 0; i < odp_pkg::NumChan; i++) begin
         p = {8'd0, s5_k_ff[i]} * {8'd0, odp_pkg::step_lut(bits_eff)};
         rsp_c_in[i] = p[7:0];
      end
   end

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pix_ff    <= 1'b0;
         s1_wr_ff     <= 1'b0;
         s2_pix_ff    <= 1'b0;
         s3_pix_ff    <= 1'b0;
         s4_pix_ff    <= 1'b0;
         s5_pix_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_pix_ff    <= s1_pix_in;
         s1_wr_ff     <= s1_wr_in;
         s2_pix_ff    <= s1_pix_ff;
         s3_pix_ff    <= s2_pix_ff;
         s4_pix_ff    <= s3_pix_ff;
         s5_pix_ff    <= s4_pix_ff;
         rsp_valid_ff <= s5_pix_ff;
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_addr_ff <= s1_addr_in;
         s1_val_ff  <= req_matrix_value;
         s1_xr_ff   <= s1_xr_in;
         s1_yr_ff   <= s1_yr_in;
         s1_xlo_ff  <= req_x_pos[odp_pkg::HalfBits-1:0];
         s1_ylo_ff  <= req_y_pos[odp_pkg::HalfBits-1:0];
         s1_a_ff    <= req_alpha_in;
         s2_a_ff    <= s1_a_ff;
         s3_prodt_ff <= s3_prodt_in;
         s3_a_ff    <= s2_a_ff;
         s4_a_ff    <= s3_a_ff;
         s5_a_ff    <= s4_a_ff;
         rsp_a_ff   <= s5_a_ff;
         for (int i = 0; i < odp_pkg::NumChan; i++) begin
            s1_c_ff[i]     <= s1_c_in[i];
            s2_c_ff[i]     <= s1_c_ff[i];
            s3_prodc_ff[i] <= s3_prodc_in[i];
            s4_q_ff[i]     <= s4_q_in[i];
            s5_k_ff[i]     <= s5_k_in[i];
            rsp_c_ff[i]    <= rsp_c_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   // a result only appears behind a pixel in the last stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s5_pix_ff))
      else $error("result without a pixel in the last stage");

   // a held result freezes the pipeline behind it
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(s5_pix_ff) && $stable(s4_pix_ff) &&
                                    $stable(s1_pix_ff) && $stable(s1_wr_ff)))
      else $error("pipeline moved under a stalled result");

   // loads never turn into results
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_func) |=> !s1_pix_ff)
      else $error("load request marked as pixel");

   // one memory access per stage slot
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      s1_wr_ff |-> !s1_pix_ff)
      else $error("write and read claimed by one slot");

   // one bit per channel gives only 0 or 255 in each channel; red and blue are checked
   a_binary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && bits_eff == 4'd1) |->
         ((rsp_red_out == 8'd0 || rsp_red_out == 8'd255) &&
          (rsp_blue_out == 8'd0 || rsp_blue_out == 8'd255)))
      else $error("two-level output out of range");
`endif

endmodule

@@ bench/tb_ordered_dither_pixel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_dither_pixel
// Self-checking bench for the ordered dither pixel block. Matrix loads and
// pixel requests go in from a queue, with random gaps on both handshakes.
// Every accepted request is run through a bit-exact predictor of the dither
// arithmetic. Each result is compared field by field with the oldest
// prediction. Register settings change between phases, while the pipe is
// empty.
// ----------------------------------------------------------------------------
module tb_ordered_dither_pixel;

   localparam logic FuncLoad  = 1'b0;
   localparam logic FuncPixel = 1'b1;

   typedef struct {
      logic               func;
      logic [11:0]        x_pos;
      logic [11:0]        y_pos;
      odp_pkg::chan_type  red;
      odp_pkg::chan_type  green;
      odp_pkg::chan_type  blue;
      odp_pkg::chan_type  alpha;
      odp_pkg::entry_type level;
   } dither_req_type;

   typedef struct {
      odp_pkg::chan_type red;
      odp_pkg::chan_type green;
      odp_pkg::chan_type blue;
      odp_pkg::chan_type alpha;
   } dither_pix_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic              req_func         = 1'b0;
   logic [11:0]       req_x_pos        = '0;
   logic [11:0]       req_y_pos        = '0;
   logic [7:0]        req_red_in       = '0;
   logic [7:0]        req_green_in     = '0;
   logic [7:0]        req_blue_in      = '0;
   logic [7:0]        req_alpha_in     = '0;
   logic signed [8:0] req_matrix_value = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [7:0]        rsp_red_out;
   logic [7:0]        rsp_green_out;
   logic [7:0]        rsp_blue_out;
   logic [7:0]        rsp_alpha_out;
   logic              csr_write        = 1'b0;
   logic [2:0]        csr_index        = '0;
   logic [11:0]       csr_wdata        = '0;

   ordered_dither_pixel dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_alpha_in     (req_alpha_in),
      .req_matrix_value (req_matrix_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_alpha_out    (rsp_alpha_out),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor copy of registers and matrix
   int                 cfg_brightness = 0;
   int                 cfg_contrast   = 256;
   int                 cfg_threshold  = 256;
   bit                 cfg_colour     = 1'b0;
   bit                 cfg_invert     = 1'b0;
   int                 cfg_bits       = 1;
   int                 cfg_size       = 0;
   odp_pkg::entry_type thresh_table [odp_pkg::TableDepth];

   // entries the generator has already loaded, so no pixel reads an empty one
   bit             gen_written [odp_pkg::TableDepth];
   dither_req_type request_q [$];
   dither_pix_type dithered_q [$];
   dither_req_type on_port;

   int fail_count    = 0;
   bit calm          = 1'b0;
   bit long_hold_arm = 1'b0;
   bit long_hold_done = 1'b0;
   int send_idle     = 0;
   int recv_idle     = 0;
   int hold_left     = 0;
   bit send_bursty   = 1'b1;
   bit recv_bursty   = 1'b1;

   function automatic logic [odp_pkg::AddrBits-1:0] tbl_idx(int x, int y);
      return odp_pkg::AddrBits'(y * odp_pkg::MaxMatrixDim + x);
   endfunction

   function automatic int eff_size();
      int sz;
      sz = cfg_size;
      if (sz > odp_pkg::MaxMatrixDim) begin
         sz = odp_pkg::MaxMatrixDim;
      end
      return sz;
   endfunction

   function automatic odp_pkg::chan_type shade_value(int c, int m, int levels);
      longint acc;
      longint q;
      longint k;
      int     cv;
      cv = cfg_invert ? 255 - c : c;
      acc = longint'(2 * cv - 255) * cfg_contrast * 256;
      acc += longint'(255) * 65536;
      acc += longint'(cfg_brightness) * 131072;
      acc += longint'(cfg_threshold) * m * 510;
      acc += 65536;
      if (acc < 0) begin
         q = 0;
      end else begin
         q = acc >>> 17;
         if (q > 255) begin
            q = 255;
         end
      end
      k = (2 * q * (levels - 1) + 255) / 510;
      return odp_pkg::chan_type'(k * (255 / (levels - 1)));
   endfunction

   task automatic dither_predict(dither_req_type rq);
      int             sz;
      int             nb;
      int             levels;
      int             m;
      int             gray;
      dither_pix_type res;
      if (rq.func == FuncLoad) begin
         if (int'(rq.x_pos) < odp_pkg::MaxMatrixDim &&
             int'(rq.y_pos) < odp_pkg::MaxMatrixDim) begin
            thresh_table[tbl_idx(int'(rq.x_pos), int'(rq.y_pos))] = rq.level;
         end
      end else begin
         sz = eff_size();
         if (sz != 0) begin
            nb = cfg_bits;
            if (nb < 1) begin
               nb = 1;
            end
            if (nb > 8) begin
               nb = 8;
            end
            levels = 1 << nb;
            m = int'(thresh_table[tbl_idx(int'(rq.x_pos) % sz, int'(rq.y_pos) % sz)]);
            if (cfg_colour) begin
               res.red   = shade_value(int'(rq.red), m, levels);
               res.green = shade_value(int'(rq.green), m, levels);
               res.blue  = shade_value(int'(rq.blue), m, levels);
            end else begin
               gray = (int'(rq.red) * 11 + int'(rq.green) * 16 + int'(rq.blue) * 5) / 32;
               res.red   = shade_value(gray, m, levels);
               res.green = res.red;
               res.blue  = res.red;
            end
            res.alpha = rq.alpha;
            dithered_q.push_back(res);
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            dither_predict(on_port);
         end
         if (!(req_valid === 1'b1 && req_stall !== 1'b0)) begin
            if ($urandom_range(0, 49) == 0) begin
               send_bursty = ~send_bursty;
            end
            if (!calm && send_bursty && send_idle == 0 && $urandom_range(0, 5) == 0) begin
               send_idle = $urandom_range(1, 10);
            end
            if (send_idle > 0 && !calm) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
               send_idle = 0;
               on_port = request_q.pop_front();
               req_valid        <= 1'b1;
               req_func         <= on_port.func;
               req_x_pos        <= on_port.x_pos;
               req_y_pos        <= on_port.y_pos;
               req_red_in       <= on_port.red;
               req_green_in     <= on_port.green;
               req_blue_in      <= on_port.blue;
               req_alpha_in     <= on_port.alpha;
               req_matrix_value <= on_port.level;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string field, odp_pkg::chan_type want,
                                       odp_pkg::chan_type got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // result monitor, also drives the receiver stall
   always @(posedge clock) begin
      dither_pix_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (dithered_q.size() == 0) begin
            $error("result with no pending pixel: rgba %0d %0d %0d %0d",
                   rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out);
            fail_count++;
         end else begin
            want = dithered_q.pop_front();
            check_field("red_out", want.red, rsp_red_out);
            check_field("green_out", want.green, rsp_green_out);
            check_field("blue_out", want.blue, rsp_blue_out);
            check_field("alpha_out", want.alpha, rsp_alpha_out);
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold_arm && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = 150;
         end
         if ($urandom_range(0, 49) == 0) begin
            recv_bursty = ~recv_bursty;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            if (recv_bursty && recv_idle == 0 && $urandom_range(0, 5) == 0) begin
               recv_idle = $urandom_range(1, 10);
            end
            if (recv_idle > 0) begin
               recv_idle--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   function automatic int rand_chan();
      int v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = 255;
         default: v = $urandom_range(0, 255);
      endcase
      return v;
   endfunction

   task automatic add_load(int x, int y, int v);
      dither_req_type rq;
      rq.func  = FuncLoad;
      rq.x_pos = 12'(x);
      rq.y_pos = 12'(y);
      rq.red   = 8'($urandom);
      rq.green = 8'($urandom);
      rq.blue  = 8'($urandom);
      rq.alpha = 8'($urandom);
      rq.level = 9'(v);
      if (x < odp_pkg::MaxMatrixDim && y < odp_pkg::MaxMatrixDim) begin
         gen_written[tbl_idx(x, y)] = 1'b1;
      end
      request_q.push_back(rq);
   endtask

   task automatic add_pixel(int x, int y, int r, int g, int b, int a);
      dither_req_type rq;
      int             sz;
      sz = eff_size();
      if (sz > 0 && !gen_written[tbl_idx(x % sz, y % sz)]) begin
         add_load(x % sz, y % sz, int'($urandom_range(0, 511)) - 256);
      end
      rq.func  = FuncPixel;
      rq.x_pos = 12'(x);
      rq.y_pos = 12'(y);
      rq.red   = 8'(r);
      rq.green = 8'(g);
      rq.blue  = 8'(b);
      rq.alpha = 8'(a);
      rq.level = 9'($urandom);
      request_q.push_back(rq);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [11:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         odp_pkg::CsrBrightness: cfg_brightness = int'($signed(data[8:0]));
         odp_pkg::CsrContrast:   cfg_contrast   = int'(data);
         odp_pkg::CsrThreshold:  cfg_threshold  = int'(data);
         odp_pkg::CsrColourMode: cfg_colour     = data[0];
         odp_pkg::CsrInvert:     cfg_invert     = data[0];
         odp_pkg::CsrBits:       cfg_bits       = int'(data[3:0]);
         odp_pkg::CsrSize:       cfg_size       = int'(data[3:0]);
         default: ;
      endcase
   endtask

   // unused upper data bits carry random junk
   task automatic program_setup(int br, int con, int thr, bit col, bit inv, int nb, int sz);
      logic [11:0] d;
      d = 12'($urandom);
      d[8:0] = br[8:0];
      write_reg(odp_pkg::CsrBrightness, d);
      write_reg(odp_pkg::CsrContrast, con[11:0]);
      write_reg(odp_pkg::CsrThreshold, thr[11:0]);
      d = 12'($urandom);
      d[0] = col;
      write_reg(odp_pkg::CsrColourMode, d);
      d = 12'($urandom);
      d[0] = inv;
      write_reg(odp_pkg::CsrInvert, d);
      d = 12'($urandom);
      d[3:0] = nb[3:0];
      write_reg(odp_pkg::CsrBits, d);
      d = 12'($urandom);
      d[3:0] = sz[3:0];
      write_reg(odp_pkg::CsrSize, d);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_setup();
      int br;
      int con;
      int thr;
      int nb;
      int sz;
      int r;
      case ($urandom_range(0, 5))
         0: br = -255;
         1: br = 255;
         default: br = int'($urandom_range(0, 160)) - 80;
      endcase
      case ($urandom_range(0, 5))
         0: con = 0;
         1: con = 4095;
         default: con = $urandom_range(128, 512);
      endcase
      case ($urandom_range(0, 5))
         0: thr = 0;
         1: thr = 4095;
         default: thr = $urandom_range(0, 512);
      endcase
      r = $urandom_range(0, 9);
      if (r == 0) begin
         nb = 0;
      end else if (r == 1) begin
         nb = $urandom_range(9, 15);
      end else begin
         nb = $urandom_range(1, 8);
      end
      r = $urandom_range(0, 19);
      if (r == 0) begin
         sz = 0;
      end else if (r < 3) begin
         sz = $urandom_range(9, 15);
      end else begin
         sz = $urandom_range(1, 8);
      end
      program_setup(br, con, thr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    nb, sz);
   endtask

   task automatic run_phase(int n);
      int x;
      int y;
      repeat (n) begin
         if ($urandom_range(0, 4) == 0) begin
            x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 7);
            y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 7);
            add_load(x, y, int'($urandom_range(0, 511)) - 256);
         end else begin
            x = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 20);
            y = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 20);
            add_pixel(x, y, rand_chan(), rand_chan(), rand_chan(), rand_chan());
         end
      end
   endtask

   // loads and zero-size pixels leave nothing to wait for, so allow drain time
   task automatic wait_quiet();
      @(negedge clock);
      while (request_q.size() != 0 || req_valid || dithered_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (12) @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // loads at the value extremes, two ignored loads, pixel with no matrix size
      add_load(0, 0, -256);
      add_load(1, 0, 255);
      add_load(0, 1, 0);
      add_load(1, 1, 128);
      add_load(8, 0, 77);
      add_load(4095, 4095, -1);
      add_pixel(0, 0, 255, 255, 255, 255);
      wait_quiet();

      program_setup(0, 256, 256, 1'b1, 1'b0, 8, 2);
      @(negedge clock);
      add_pixel(0, 0, 0, 0, 0, 0);
      add_pixel(1, 0, 255, 255, 255, 255);
      add_pixel(4095, 4095, 128, 64, 200, 17);
      add_pixel(2, 1, 1, 254, 127, 128);
      add_pixel(4094, 1, 255, 0, 170, 85);
      wait_quiet();

      // gray, inverted, bits of zero, size of one
      program_setup(-255, 4095, 4095, 1'b0, 1'b1, 0, 1);
      @(negedge clock);
      add_pixel(0, 0, 0, 0, 0, 0);
      add_pixel(3, 7, 255, 255, 255, 255);
      add_pixel(4095, 0, 100, 200, 50, 9);
      wait_quiet();

      // oversized matrix and bits above eight
      program_setup(255, 0, 0, 1'b0, 1'b0, 15, 15);
      @(negedge clock);
      add_pixel(7, 7, 10, 20, 30, 40);
      add_pixel(4095, 2048, 255, 0, 255, 0);
      add_pixel(12, 5, 0, 255, 0, 255);
      wait_quiet();

      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 4) begin
            program_setup(0, 256, 128, 1'b1, 1'b0, 3, 4);
         end else begin
            random_setup();
         end
         @(negedge clock);
         if (ph == 11) begin
            calm = 1'b1;
         end
         run_phase(36);
         if (ph == 4) begin
            long_hold_arm = 1'b1;
         end
         wait_quiet();
      end

      if (fail_count == 0 && dithered_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
